// ----- rtl/lwbc_pkg.sv -----
// Shared constants, codes and structures of the LRU write-back node cache.
`default_nettype none

package lwbc_pkg;

    localparam int ENTRIES   = 16;
    localparam int DATA_BITS = 64;
    localparam int ADDR_BITS = 32;
    localparam int STAMP_W   = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_HIT  = 2'd0,
        KIND_MISS = 2'd1,
        KIND_WB   = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    // Contents of one slot as seen by the controller.
    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
    } t_slot;

    // Lookup token that travels down the chain, one cell per cycle.
    typedef struct packed {
        logic                 active;
        logic [ADDR_BITS-1:0] addr;
        logic                 hit;
        t_idx                 hit_idx;
        logic                 empty;
        t_idx                 empty_idx;
        logic                 best_set;
        t_idx                 best_idx;
        logic [STAMP_W-1:0]   best_stamp;
    } t_probe;

    // Update broadcast from the controller to the addressed cell.
    typedef struct packed {
        logic                 en;
        t_idx                 idx;
        logic                 valid_we;
        logic                 valid;
        logic                 dirty_we;
        logic                 dirty;
        logic                 line_we;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic                 stamp_we;
        logic [STAMP_W-1:0]   stamp;
    } t_update;

endpackage

`default_nettype wire

// ----- rtl/lwbc_cell.sv -----
// One cache slot with its stage of the lookup chain.
`default_nettype none

module lwbc_cell
    import lwbc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_idx    i_index,
    input  wire t_probe  i_probe,
    output t_probe       o_probe,
    input  wire t_update i_update,
    output t_slot        o_slot
);

    logic                 r_valid;
    logic                 r_dirty;
    logic [STAMP_W-1:0]   r_stamp;
    logic [ADDR_BITS-1:0] r_addr;
    logic [DATA_BITS-1:0] r_data;
    t_probe               r_probe;
    t_probe               n_probe;
    logic                 sel;

    assign sel = i_update.en && (i_update.idx == i_index);

    // Fold this slot into the token: first match, first empty, oldest stamp.
    always_comb begin
        n_probe = i_probe;
        if (i_probe.active) begin
            if (r_valid && (r_addr == i_probe.addr) && !i_probe.hit) begin
                n_probe.hit     = 1'b1;
                n_probe.hit_idx = i_index;
            end
            if (!r_valid && !i_probe.empty) begin
                n_probe.empty     = 1'b1;
                n_probe.empty_idx = i_index;
            end
            if (!i_probe.best_set || (r_stamp < i_probe.best_stamp)) begin
                n_probe.best_set   = 1'b1;
                n_probe.best_idx   = i_index;
                n_probe.best_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_stamp <= '0;
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
            if (sel && i_update.valid_we) r_valid <= i_update.valid;
            if (sel && i_update.dirty_we) r_dirty <= i_update.dirty;
            if (sel && i_update.stamp_we) r_stamp <= i_update.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && i_update.line_we) begin
            r_addr <= i_update.addr;
            r_data <= i_update.data;
        end
    end

    assign o_probe = r_probe;
    assign o_slot  = '{valid: r_valid, dirty: r_dirty, addr: r_addr, data: r_data};

endmodule

`default_nettype wire

// ----- rtl/lwbc_ctrl.sv -----
// Command sequencer, slot read-out mux and output register of the cache.
`default_nettype none

module lwbc_ctrl
    import lwbc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [ADDR_BITS-1:0] i_address,
    input  wire logic [DATA_BITS-1:0] i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_kind,
    output logic [ADDR_BITS-1:0]      o_out_address,
    output logic [DATA_BITS-1:0]      o_out_data,
    output logic                      o_last,
    output t_probe                    o_probe,
    input  wire t_probe               i_tail,
    output t_update                   o_update,
    input  wire t_slot                i_slots [ENTRIES]
);

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_SCAN       = 6'b000010,
        S_VICTIM     = 6'b000100,
        S_FINISH     = 6'b001000,
        S_FLUSH      = 6'b010000,
        S_FLUSH_DONE = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [DATA_BITS-1:0] r_data, n_data;
    logic [STAMP_W-1:0]   r_clock, n_clock;
    logic                 r_hit, n_hit;
    logic                 r_empty, n_empty;
    t_idx                 r_sel, n_sel;

    logic                 r_out_valid;
    t_kind                r_kind;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [DATA_BITS-1:0] r_out_data;
    logic                 r_last;

    logic                 out_free;
    logic                 emit;
    t_kind                e_kind;
    logic [ADDR_BITS-1:0] e_addr;
    logic [DATA_BITS-1:0] e_data;
    logic                 e_last;
    t_slot                slot;
    t_probe               probe;
    t_update              upd;
    logic                 flush_end;

    assign out_free  = !r_out_valid || i_ready;
    assign slot      = i_slots[r_sel];
    assign flush_end = (r_sel == IDX_W'(ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_data  = r_data;
        n_clock = r_clock;
        n_hit   = r_hit;
        n_empty = r_empty;
        n_sel   = r_sel;
        emit    = 1'b0;
        e_kind  = KIND_DONE;
        e_addr  = '0;
        e_data  = '0;
        e_last  = 1'b0;
        probe   = '0;
        upd     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = t_cmd'(i_cmd);
                    n_addr = i_address;
                    n_data = i_data;
                    if (t_cmd'(i_cmd) == CMD_FLUSH) begin
                        n_sel   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_clock      = r_clock + 1'b1;
                        probe.active = 1'b1;
                        probe.addr   = i_address;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Wait for the token to leave the last cell.
                if (i_tail.active) begin
                    n_hit   = i_tail.hit;
                    n_empty = i_tail.empty;
                    if (i_tail.hit)        n_sel = i_tail.hit_idx;
                    else if (i_tail.empty) n_sel = i_tail.empty_idx;
                    else                   n_sel = i_tail.best_idx;
                    n_state = S_VICTIM;
                end
            end
            S_VICTIM: begin
                if (!r_hit && !r_empty && slot.dirty) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_kind  = KIND_WB;
                        e_addr  = slot.addr;
                        e_data  = slot.data;
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    upd.en  = 1'b1;
                    upd.idx = r_sel;
                    n_state = S_IDLE;
                    if (r_hit) begin
                        upd.stamp_we = 1'b1;
                        upd.stamp    = r_clock;
                        if (r_cmd == CMD_READ) begin
                            e_kind = KIND_HIT;
                            e_addr = r_addr;
                            e_data = slot.data;
                        end else if (r_cmd == CMD_WRITE) begin
                            upd.line_we  = 1'b1;
                            upd.addr     = r_addr;
                            upd.data     = r_data;
                            upd.dirty_we = 1'b1;
                            upd.dirty    = 1'b1;
                        end
                    end else if (r_cmd == CMD_READ) begin
                        e_kind = KIND_MISS;
                        e_addr = r_addr;
                        // Drop the evicted entry; an empty slot stays as it is.
                        if (!r_empty) begin
                            upd.valid_we = 1'b1;
                            upd.valid    = 1'b0;
                            upd.dirty_we = 1'b1;
                            upd.dirty    = 1'b0;
                        end
                    end else begin
                        upd.valid_we = 1'b1;
                        upd.valid    = 1'b1;
                        upd.line_we  = 1'b1;
                        upd.addr     = r_addr;
                        upd.data     = r_data;
                        upd.dirty_we = 1'b1;
                        upd.dirty    = (r_cmd == CMD_WRITE);
                        upd.stamp_we = 1'b1;
                        upd.stamp    = r_clock;
                    end
                end
            end
            S_FLUSH: begin
                if (slot.valid && slot.dirty) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        e_kind       = KIND_WB;
                        e_addr       = slot.addr;
                        e_data       = slot.data;
                        upd.en       = 1'b1;
                        upd.idx      = r_sel;
                        upd.dirty_we = 1'b1;
                        upd.dirty    = 1'b0;
                        if (flush_end) n_state = S_FLUSH_DONE;
                        else           n_sel   = r_sel + 1'b1;
                    end
                end else begin
                    if (flush_end) n_state = S_FLUSH_DONE;
                    else           n_sel   = r_sel + 1'b1;
                end
            end
            S_FLUSH_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock     <= '0;
            r_hit       <= 1'b0;
            r_empty     <= 1'b0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clock <= n_clock;
            r_hit   <= n_hit;
            r_empty <= n_empty;
            r_sel   <= n_sel;
            if (emit)         r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_data <= n_data;
        if (emit) begin
            r_kind     <= e_kind;
            r_out_addr <= e_addr;
            r_out_data <= e_data;
            r_last     <= e_last;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_address = r_out_addr;
    assign o_out_data    = r_out_data;
    assign o_last        = r_last;
    assign o_probe       = probe;
    assign o_update      = upd;

endmodule

`default_nettype wire

// ----- rtl/lru_write_back_node_cache_top.sv -----
// Top level of the fully associative LRU write-back node cache.
//
//  channel  | direction | signals                                   | transaction
//  ---------+-----------+-------------------------------------------+----------------------
//  command  | in        | i_valid/o_ready, i_cmd, i_address, i_data | read, fill, write, flush
//  result   | out       | o_valid/i_ready, o_kind, o_out_address,   | hit, miss, write-back,
//           |           | o_out_data, o_last                        | done (o_last on final)
//
// A read, fill or write sends a lookup token down the chain of ENTRIES cells, one
// cell per cycle. A dirty victim write-back leaves in the victim state, which every lookup
// passes through, and so delays nothing while the result port is ready. A flush visits one
// slot per cycle while the result port takes its write-backs.
// A stalled result port holds the sequencer at its next emission.
// Reset (i_rst_n low at a clock edge) empties every slot and zeroes the access clock
// at once; commands are taken as soon as reset is released.
`default_nettype none

module lru_write_back_node_cache_top
    import lwbc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [ADDR_BITS-1:0] i_address,
    input  wire logic [DATA_BITS-1:0] i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_kind,
    output logic [ADDR_BITS-1:0]      o_out_address,
    output logic [DATA_BITS-1:0]      o_out_data,
    output logic                      o_last
);

    // Token links: link[0] is fed by the sequencer, link[ENTRIES] returns to it.
    t_probe  link  [ENTRIES+1];
    t_slot   slots [ENTRIES];
    t_update upd;

    lwbc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_address     (i_address),
        .i_data        (i_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_out_address (o_out_address),
        .o_out_data    (o_out_data),
        .o_last        (o_last),
        .o_probe       (link[0]),
        .i_tail        (link[ENTRIES]),
        .o_update      (upd),
        .i_slots       (slots)
    );

    // Each cell holds one slot and advances the lookup token by one stage.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lwbc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(g)),
            .i_probe  (link[g]),
            .o_probe  (link[g+1]),
            .i_update (upd),
            .o_slot   (slots[g])
        );
    end

endmodule

`default_nettype wire
